// ----- hw/rtl/graph_bridge_finder_core_assert.svh -----
`ifndef GRAPH_BRIDGE_FINDER_CORE_ASSERT_SVH
`define GRAPH_BRIDGE_FINDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfc check failed");

// next-cycle implication, sampled on clk, off during reset
`define BFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfc check failed");

`endif

// ----- hw/rtl/bfc_pkg.sv -----
package bfc_pkg;

    localparam int NODE_W        = 7;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic              REG_NODE_COUNT   = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN,
        ST_EDGE,
        ST_DISC,
        ST_POP,
        ST_FINISH
    } state_t;

endpackage

// ----- hw/rtl/bfc_edge_if.sv -----
interface bfc_edge_if;
    import bfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] end_a;
    logic [NODE_W-1:0] end_b;
    logic              last_edge;

    modport source (output valid, end_a, end_b, last_edge, input ready);
    modport sink   (input valid, end_a, end_b, last_edge, output ready);
endinterface

// ----- hw/rtl/bfc_result_if.sv -----
interface bfc_result_if;
    import bfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] bridge_parent;
    logic [NODE_W-1:0] bridge_child;
    logic              no_bridges;
    logic              edges_dropped;
    logic              is_last;

    modport source (output valid, bridge_parent, bridge_child, no_bridges, edges_dropped,
                    is_last, input ready);
    modport sink   (input valid, bridge_parent, bridge_child, no_bridges, edges_dropped,
                    is_last, output ready);
endinterface

// ----- hw/rtl/graph_bridge_finder_core.sv -----
// Edge words load at one per cycle while the core is idle; a word without
// last_edge yields no result. The last edge starts the search: each visited
// node scans all held edges (edge memory read, then a discovery memory read
// for an already visited neighbour), and each return to a parent reads the
// stack memory; a bridge word or the final result word may wait for the
// output register to drain.
// rst_n (async, active low) clears control state; memories are not cleared.
module graph_bridge_finder_core #(
    parameter int MAX_NODES = bfc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = bfc_pkg::DEF_MAX_EDGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bfc_edge_if.sink                        edge_in,
    bfc_result_if.source                    bridge_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bfc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bfc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bfc_pkg::*;

    `include "graph_bridge_finder_core_assert.svh"

    localparam int NAW = $clog2(MAX_NODES + 1);
    localparam int NW  = ((NAW > NODE_W) ? NAW : NODE_W) + 1;
    localparam int DW  = $clog2(MAX_NODES + 2);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW  = $clog2(MAX_EDGES + 1);
    localparam int SAW = $clog2(MAX_NODES);
    localparam int FW  = NAW + SW + 1 + EAW + DW + DW;

    state_t state_reg, state_next;

    logic [NODE_W-1:0] node_count_reg;
    logic [SW-1:0]     edges_held_reg, edges_held_next;
    logic              drop_reg, drop_next;
    logic [MAX_NODES:0] visited_reg, visited_next;
    logic [DW-1:0]     next_order_reg, next_order_next;
    logic [NW-1:0]     root_reg, root_next;
    logic [SAW-1:0]    sp_reg, sp_next;

    logic [NAW-1:0]    top_node_reg, top_node_next;
    logic [SW-1:0]     top_scan_reg, top_scan_next;
    logic              top_enone_reg, top_enone_next;
    logic [EAW-1:0]    top_enter_reg, top_enter_next;
    logic [DW-1:0]     top_disc_reg, top_disc_next;
    logic [DW-1:0]     top_low_reg, top_low_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [NAW-1:0]    pend_parent_reg, pend_parent_next;
    logic [NAW-1:0]    pend_child_reg, pend_child_next;

    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] out_parent_reg, out_parent_next;
    logic [NODE_W-1:0] out_child_reg, out_child_next;
    logic              out_none_reg, out_none_next;
    logic              out_drop_reg, out_drop_next;
    logic              out_last_reg, out_last_next;

    logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
    logic [DW-1:0]       disc_mem [MAX_NODES+1];
    logic [FW-1:0]       stack_mem [MAX_NODES];

    logic [2*NODE_W-1:0] edge_rd_reg;
    logic [DW-1:0]       disc_rd_reg;
    logic [FW-1:0]       stack_rd_reg;

    logic                edge_we, edge_re;
    logic [2*NODE_W-1:0] edge_wdata;
    logic [EAW-1:0]      edge_raddr;
    logic                disc_we, disc_re;
    logic [NAW-1:0]      disc_waddr, disc_raddr;
    logic                stack_we, stack_re;
    logic [SAW-1:0]      stack_waddr, stack_raddr;
    logic [FW-1:0]       stack_wdata;

    logic [NW-1:0]     eff;
    logic [NW-1:0]     in_a, in_b;
    logic              in_ok;
    logic              out_free;
    logic [NW-1:0]     ea, eb, un, vw;
    logic              e_skip, e_match;
    logic [NAW-1:0]    p_node;
    logic [SW-1:0]     p_scan;
    logic              p_enone;
    logic [EAW-1:0]    p_enter;
    logic [DW-1:0]     p_disc, p_low;
    logic              is_bridge;

    assign pready = 1'b1;
    assign prdata = CFG_DATA_W'(node_count_reg);

    assign eff = (NW'(node_count_reg) > NW'(MAX_NODES)) ? NW'(MAX_NODES)
                                                         : NW'(node_count_reg);
    assign in_a  = NW'(edge_in.end_a);
    assign in_b  = NW'(edge_in.end_b);
    assign in_ok = (in_a != '0) && (in_b != '0) && (in_a <= eff) && (in_b <= eff)
                   && (edges_held_reg < SW'(MAX_EDGES));

    assign out_free = !out_valid_reg || bridge_out.ready;

    assign ea = NW'(edge_rd_reg[2*NODE_W-1:NODE_W]);
    assign eb = NW'(edge_rd_reg[NODE_W-1:0]);
    assign un = NW'(top_node_reg);
    assign e_match = (ea == un) || (eb == un);
    assign vw = (ea == un) ? eb : ea;
    assign e_skip = (!top_enone_reg && (top_enter_reg == top_scan_reg[EAW-1:0]))
                    || (ea == '0) || (eb == '0) || (ea > eff) || (eb > eff) || !e_match;

    assign {p_node, p_scan, p_enone, p_enter, p_disc, p_low} = stack_rd_reg;
    assign is_bridge = top_low_reg > p_disc;

    assign edge_in.ready            = (state_reg == ST_IDLE);
    assign bridge_out.valid         = out_valid_reg;
    assign bridge_out.bridge_parent = out_parent_reg;
    assign bridge_out.bridge_child  = out_child_reg;
    assign bridge_out.no_bridges    = out_none_reg;
    assign bridge_out.edges_dropped = out_drop_reg;
    assign bridge_out.is_last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_NODE_COUNT))
        begin
            node_count_reg <= pwdata[NODE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edges_held_reg[EAW-1:0]] <= edge_wdata;
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (disc_we)
        begin
            disc_mem[disc_waddr] <= next_order_reg;
        end
        if (disc_re)
        begin
            disc_rd_reg <= disc_mem[disc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edges_held_reg <= '0;
            drop_reg       <= 1'b0;
            visited_reg    <= '0;
            next_order_reg <= DW'(1);
            root_reg       <= NW'(1);
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edges_held_reg <= edges_held_next;
            drop_reg       <= drop_next;
            visited_reg    <= visited_next;
            next_order_reg <= next_order_next;
            root_reg       <= root_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_node_reg    <= top_node_next;
        top_scan_reg    <= top_scan_next;
        top_enone_reg   <= top_enone_next;
        top_enter_reg   <= top_enter_next;
        top_disc_reg    <= top_disc_next;
        top_low_reg     <= top_low_next;
        pend_parent_reg <= pend_parent_next;
        pend_child_reg  <= pend_child_next;
        out_parent_reg  <= out_parent_next;
        out_child_reg   <= out_child_next;
        out_none_reg    <= out_none_next;
        out_drop_reg    <= out_drop_next;
        out_last_reg    <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        edges_held_next  = edges_held_reg;
        drop_next        = drop_reg;
        visited_next     = visited_reg;
        next_order_next  = next_order_reg;
        root_next        = root_reg;
        sp_next          = sp_reg;
        top_node_next    = top_node_reg;
        top_scan_next    = top_scan_reg;
        top_enone_next   = top_enone_reg;
        top_enter_next   = top_enter_reg;
        top_disc_next    = top_disc_reg;
        top_low_next     = top_low_reg;
        pend_valid_next  = pend_valid_reg;
        pend_parent_next = pend_parent_reg;
        pend_child_next  = pend_child_reg;
        out_valid_next   = out_valid_reg && !bridge_out.ready;
        out_parent_next  = out_parent_reg;
        out_child_next   = out_child_reg;
        out_none_next    = out_none_reg;
        out_drop_next    = out_drop_reg;
        out_last_next    = out_last_reg;

        edge_we     = 1'b0;
        edge_wdata  = {edge_in.end_a, edge_in.end_b};
        edge_re     = 1'b0;
        edge_raddr  = top_scan_reg[EAW-1:0];
        disc_we     = 1'b0;
        disc_waddr  = root_reg[NAW-1:0];
        disc_re     = 1'b0;
        disc_raddr  = vw[NAW-1:0];
        stack_we    = 1'b0;
        stack_waddr = sp_reg;
        stack_wdata = {top_node_reg, top_scan_reg + SW'(1), top_enone_reg, top_enter_reg,
                       top_disc_reg, top_low_reg};
        stack_re    = 1'b0;
        stack_raddr = sp_reg - SAW'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (edge_in.valid)
                begin
                    if (in_ok)
                    begin
                        edge_we         = 1'b1;
                        edges_held_next = edges_held_reg + SW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (edge_in.last_edge)
                    begin
                        root_next  = NW'(1);
                        state_next = ST_ROOT;
                    end
                end
            end

            ST_ROOT:
            begin
                if (root_reg > eff)
                begin
                    state_next = ST_FINISH;
                end
                else if (visited_reg[root_reg[NAW-1:0]])
                begin
                    root_next = root_reg + NW'(1);
                end
                else
                begin
                    disc_we                          = 1'b1;
                    visited_next[root_reg[NAW-1:0]]  = 1'b1;
                    next_order_next                  = next_order_reg + DW'(1);
                    sp_next                          = '0;
                    top_node_next                    = root_reg[NAW-1:0];
                    top_scan_next                    = '0;
                    top_enone_next                   = 1'b1;
                    top_enter_next                   = '0;
                    top_disc_next                    = next_order_reg;
                    top_low_next                     = next_order_reg;
                    state_next                       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (top_scan_reg < edges_held_reg)
                begin
                    edge_re    = 1'b1;
                    state_next = ST_EDGE;
                end
                else if (sp_reg == '0)
                begin
                    root_next  = root_reg + NW'(1);
                    state_next = ST_ROOT;
                end
                else
                begin
                    stack_re   = 1'b1;
                    state_next = ST_POP;
                end
            end

            ST_EDGE:
            begin
                top_scan_next = top_scan_reg + SW'(1);
                state_next    = ST_SCAN;
                if (!e_skip)
                begin
                    if (!visited_reg[vw[NAW-1:0]])
                    begin
                        stack_we                     = 1'b1;
                        sp_next                      = sp_reg + SAW'(1);
                        disc_we                      = 1'b1;
                        disc_waddr                   = vw[NAW-1:0];
                        visited_next[vw[NAW-1:0]]    = 1'b1;
                        next_order_next              = next_order_reg + DW'(1);
                        top_node_next                = vw[NAW-1:0];
                        top_scan_next                = '0;
                        top_enone_next               = 1'b0;
                        top_enter_next               = top_scan_reg[EAW-1:0];
                        top_disc_next                = next_order_reg;
                        top_low_next                 = next_order_reg;
                    end
                    else
                    begin
                        disc_re    = 1'b1;
                        state_next = ST_DISC;
                    end
                end
            end

            ST_DISC:
            begin
                if (disc_rd_reg < top_low_reg)
                begin
                    top_low_next = disc_rd_reg;
                end
                state_next = ST_SCAN;
            end

            ST_POP:
            begin
                if (!(is_bridge && pend_valid_reg && !out_free))
                begin
                    if (is_bridge)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_parent_next = NODE_W'(pend_parent_reg);
                            out_child_next  = NODE_W'(pend_child_reg);
                            out_none_next   = 1'b0;
                            out_drop_next   = drop_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_parent_next = p_node;
                        pend_child_next  = top_node_reg;
                    end
                    sp_next        = sp_reg - SAW'(1);
                    top_node_next  = p_node;
                    top_scan_next  = p_scan;
                    top_enone_next = p_enone;
                    top_enter_next = p_enter;
                    top_disc_next  = p_disc;
                    top_low_next   = (top_low_reg < p_low) ? top_low_reg : p_low;
                    state_next     = ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_parent_next = pend_valid_reg ? NODE_W'(pend_parent_reg) : '0;
                    out_child_next  = pend_valid_reg ? NODE_W'(pend_child_reg) : '0;
                    out_none_next   = !pend_valid_reg;
                    out_drop_next   = drop_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    edges_held_next = '0;
                    drop_next       = 1'b0;
                    visited_next    = '0;
                    next_order_next = DW'(1);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BFC_ASSERT_IMP(a_busy_blocks_input, state_reg != ST_IDLE, !edge_in.ready)
    `BFC_ASSERT_IMP(a_pending_needs_two, pend_valid_reg, next_order_reg >= DW'(3))
    `BFC_ASSERT_IMP(a_empty_is_last, out_valid_reg && out_none_reg, out_last_reg)
    `BFC_ASSERT_NXT(a_finish_clears, (state_reg == ST_FINISH) && out_free,
        (state_reg == ST_IDLE) && (edges_held_reg == '0) && !pend_valid_reg)

endmodule

// ----- bench/bfc_checker.sv -----
`timescale 1ns / 100ps

module bfc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    bfc_edge_if                             edge_mon,
    bfc_result_if                           res_mon,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [bfc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bfc_pkg::CFG_DATA_W-1:0]  pwdata,
    output int                              fail_count,
    output int                              words_owed,
    output int                              words_seen
);
    import bfc_pkg::*;

    localparam int NO_ENTRY = -1;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] child;
        logic              none;
        logic              dropped;
        logic              last;
    } bridge_word_t;

    bridge_word_t      bridge_q[$];
    logic [NODE_W-1:0] node_cnt;
    int                ends_a[DEF_MAX_EDGES];
    int                ends_b[DEF_MAX_EDGES];
    int                held;
    bit                drop_seen;
    int                disc[DEF_MAX_NODES + 1];
    int                lowv[DEF_MAX_NODES + 1];
    int                stk_node[DEF_MAX_NODES + 1];
    int                stk_scan[DEF_MAX_NODES + 1];
    int                stk_enter[DEF_MAX_NODES + 1];
    int                next_disc;

    function automatic int eff_nodes();
        return (node_cnt > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(node_cnt);
    endfunction

    function automatic void clear_graph();
        held = 0;
        drop_seen = 0;
        foreach (disc[k]) disc[k] = 0;
        next_disc = 1;
    endfunction

    function automatic void enter_node(int v, int via, inout int sp);
        disc[v] = next_disc;
        lowv[v] = next_disc;
        next_disc++;
        stk_node[sp] = v;
        stk_scan[sp] = 0;
        stk_enter[sp] = via;
        sp++;
    endfunction

    function automatic void find_bridges();
        int           n;
        int           sp;
        int           u;
        int           i;
        int           a;
        int           b;
        int           v;
        int           p;
        bit           moved;
        bridge_word_t found[$];
        bridge_word_t w;
        n = eff_nodes();
        for (int s = 1; s <= n; s++) begin
            if (disc[s] != 0)
                continue;
            sp = 0;
            enter_node(s, NO_ENTRY, sp);
            while (sp > 0) begin
                u = stk_node[sp-1];
                moved = 0;
                while (stk_scan[sp-1] < held) begin
                    i = stk_scan[sp-1];
                    stk_scan[sp-1] = i + 1;
                    a = ends_a[i];
                    b = ends_b[i];
                    if (i == stk_enter[sp-1] || a > n || b > n || a == 0 || b == 0)
                        continue;
                    if (a == u)
                        v = b;
                    else if (b == u)
                        v = a;
                    else
                        continue;
                    if (disc[v] == 0) begin
                        if (sp <= DEF_MAX_NODES)
                            enter_node(v, i, sp);
                        moved = 1;
                        break;
                    end
                    if (disc[v] < lowv[u])
                        lowv[u] = disc[v];
                end
                if (moved)
                    continue;
                sp--;
                if (sp > 0) begin
                    p = stk_node[sp-1];
                    if (lowv[u] < lowv[p])
                        lowv[p] = lowv[u];
                    if (lowv[u] > disc[p] && found.size() < DEF_MAX_NODES) begin
                        w = '0;
                        w.parent = NODE_W'(p);
                        w.child = NODE_W'(u);
                        w.dropped = drop_seen;
                        found = {found, w};
                    end
                end
            end
        end
        if (found.size() == 0) begin
            w = '0;
            w.none = 1;
            w.dropped = drop_seen;
            found = {found, w};
        end
        found[found.size()-1].last = 1;
        foreach (found[k]) bridge_q = {bridge_q, found[k]};
        clear_graph();
    endfunction

    function automatic void take_edge(int a, int b, bit last);
        int n;
        n = eff_nodes();
        if (a == 0 || b == 0 || a > n || b > n || held >= DEF_MAX_EDGES) begin
            drop_seen = 1;
        end
        else begin
            ends_a[held] = a;
            ends_b[held] = b;
            held++;
        end
        if (last)
            find_bridges();
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_word();
        bridge_word_t want;
        if (bridge_q.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
            return;
        end
        want = bridge_q.pop_front();
        if (res_mon.bridge_parent !== want.parent)
            report_mismatch("bridge_parent", res_mon.bridge_parent, want.parent);
        if (res_mon.bridge_child !== want.child)
            report_mismatch("bridge_child", res_mon.bridge_child, want.child);
        if (res_mon.no_bridges !== want.none)
            report_mismatch("no_bridges", res_mon.no_bridges, want.none);
        if (res_mon.edges_dropped !== want.dropped)
            report_mismatch("edges_dropped", res_mon.edges_dropped, want.dropped);
        if (res_mon.is_last !== want.last)
            report_mismatch("is_last", res_mon.is_last, want.last);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            node_cnt = NODE_COUNT_RESET;
            bridge_q.delete();
            clear_graph();
            fail_count = 0;
            words_seen = 0;
        end
        else begin
            if (psel && penable && pwrite && pready
                && paddr == (CFG_ADDR_W'(REG_NODE_COUNT) << 2))
                node_cnt = pwdata[NODE_W-1:0];
            if (edge_mon.valid && edge_mon.ready)
                take_edge(edge_mon.end_a, edge_mon.end_b, edge_mon.last_edge);
            if (res_mon.valid && res_mon.ready) begin
                check_word();
                words_seen++;
            end
        end
        words_owed = bridge_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bfc_pkg::*;

    localparam int LIMIT = 3000000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    words_owed;
    int                    words_seen;
    int                    src_idle;
    int                    snk_idle;
    int                    cycles;
    int                    edges_sent;
    int                    graphs_sent;
    int                    cur_nodes;

    bfc_edge_if   edge_ch();
    bfc_result_if res_ch();

    graph_bridge_finder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_ch),
        .bridge_out (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    bfc_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_mon   (edge_ch),
        .res_mon    (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .words_owed (words_owed),
        .words_seen (words_seen)
    );

    initial clk = 0;
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("graph_bridge_finder_core test failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    task automatic send_edge(int a, int b, bit last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            edge_ch.valid <= 0;
            @(posedge clk);
        end
        edge_ch.valid     <= 1;
        edge_ch.end_a     <= NODE_W'(a);
        edge_ch.end_b     <= NODE_W'(b);
        edge_ch.last_edge <= last;
        do
            @(posedge clk);
        while (!edge_ch.ready);
        edges_sent++;
        if (last)
            graphs_sent++;
    endtask

    task automatic drain();
        edge_ch.valid <= 0;
        @(posedge clk);
        while (words_owed != 0)
            @(posedge clk);
    endtask

    task automatic set_nodes(int v);
        drain();
        repeat (20) @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= CFG_ADDR_W'(REG_NODE_COUNT) << 2;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge clk);
        cur_nodes = v;
    endtask

    function automatic int pick_end(int n);
        if (n == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(1, n);
    endfunction

    task automatic random_graph();
        int n;
        int k;
        int a;
        int b;
        n = (cur_nodes > DEF_MAX_NODES) ? DEF_MAX_NODES : cur_nodes;
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        for (int j = 0; j < k; j++)
        begin
            if (n > 1 && j + 1 < n && $urandom_range(0, 1) == 1)
            begin
                a = j + 2;
                b = $urandom_range(1, j + 1);
            end
            else
            begin
                a = pick_end(n);
                b = pick_end(n);
            end
            send_edge(a, b, j == k - 1);
        end
    endtask

    task automatic random_phase(int src, int snk, int quota);
        int start;
        int r;
        src_idle = src;
        snk_idle = snk;
        start = edges_sent;
        while (edges_sent - start < quota)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    set_nodes(DEF_MAX_NODES);
                else if (r == 1)
                    set_nodes(127);
                else if (r == 2)
                    set_nodes(0);
                else if (r == 3)
                    set_nodes(1);
                else
                    set_nodes($urandom_range(2, 14));
            end
            random_graph();
            if ($urandom_range(0, 3) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n             <= 0;
        psel              <= 0;
        penable           <= 0;
        pwrite            <= 0;
        paddr             <= '0;
        pwdata            <= '0;
        edge_ch.valid     <= 0;
        edge_ch.end_a     <= '0;
        edge_ch.end_b     <= '0;
        edge_ch.last_edge <= 0;
        edges_sent        = 0;
        graphs_sent       = 0;
        cur_nodes         = DEF_MAX_NODES;
        src_idle          = 0;
        snk_idle          = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_edge(1, 64, 1);
        send_edge(0, 5, 0);
        send_edge(65, 2, 0);
        send_edge(127, 0, 0);
        send_edge(2, 2, 0);
        send_edge(1, 2, 0);
        send_edge(1, 2, 0);
        send_edge(2, 3, 1);
        send_edge(1, 2, 0);
        send_edge(2, 3, 0);
        send_edge(3, 1, 1);
        set_nodes(127);
        send_edge(64, 63, 1);
        set_nodes(DEF_MAX_NODES);
        send_edge(1, 50, 0);
        set_nodes(10);
        send_edge(1, 2, 1);
        set_nodes(0);
        send_edge(1, 1, 0);
        send_edge(3, 4, 1);
        set_nodes(1);
        send_edge(1, 1, 1);
        set_nodes(3);
        for (int j = 0; j < DEF_MAX_EDGES + 2; j++)
            send_edge((j % 2) + 1, (j % 2) + 2, j == DEF_MAX_EDGES + 1);

        random_phase(18, 85, 40);
        drain();
        random_phase(85, 18, 40);
        random_phase(0, 0, 40);

        drain();
        repeat (100) @(posedge clk);
        $display("covered %0d edge words in %0d graphs, %0d result words checked",
                 edges_sent, graphs_sent, words_seen);
        $display("node counts from 0 to 127, drops, self-loops, parallel edges, full store");
        if (fail_count == 0)
            $display("graph_bridge_finder_core test passed");
        else
            $display("graph_bridge_finder_core test failed");
        $finish;
    end

endmodule
